// ----- hdl/urrb_pkg.sv -----
package urrb_pkg;

   // Stream widths: tdata padded to whole bytes
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   // Operation carried in req_tuser
   typedef enum logic [1:0] {
      OP_RX_BYTE    = 2'd0,
      OP_HOST_READ  = 2'd1,
      OP_HOST_WRITE = 2'd2,
      OP_TX_READY   = 2'd3
   } op_type;

   // Read status codes; frame and overrun codes are the raw flag pair
   localparam logic [2:0] RS_OK       = 3'd0;
   localparam logic [2:0] RS_OVERFLOW = 3'd4;
   localparam logic [2:0] RS_NO_DATA  = 3'd5;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_FIN
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_in;
      logic exec;
      logic load_out;
   } ctrl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ----- hdl/urrb_ctrl.sv -----
module urrb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  urrb_pkg::dp_status_type status,
   output urrb_pkg::ctrl_cmd_type  cmd
);
   import urrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one transaction: capture, execute, hand to output register
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.load_in  = 1'b0;
      cmd.exec     = 1'b0;
      cmd.load_out = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Refuse transactions while reset is held
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_in = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/urrb_datapath.sv -----
module urrb_datapath #(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [urrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [urrb_pkg::REQ_USER_W-1:0]   req_tuser,
   input  urrb_pkg::ctrl_cmd_type            cmd,
   output urrb_pkg::dp_status_type           status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [urrb_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import urrb_pkg::*;

   localparam int RX_PW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TX_PW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [RX_PW-1:0] RX_LAST = RX_PW'(RX_DEPTH - 1);
   localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

   // Held input transaction
   op_type      op_ff;
   logic [7:0]  byte_ff;
   logic        fe_ff;
   logic        ovr_ff;

   // Ring pointers and flags
   logic [RX_PW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [TX_PW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [2:0]       last_error_ff, last_error_in;
   logic             irq_on_ff, irq_on_in;

   // Next indices and fill checks
   logic [RX_PW-1:0] rx_nh, rx_nt;
   logic [TX_PW-1:0] tx_nh, tx_nt;
   logic             rx_empty, rx_full, tx_empty, tx_full;

   // Memory controls
   logic rx_we, rx_re, tx_we, tx_re;
   logic [7:0] rx_store [RX_DEPTH];
   logic [7:0] tx_store [TX_DEPTH];
   logic [7:0] rx_rdata_ff, tx_rdata_ff;

   // Staged result flags
   logic [2:0] st_status_ff, st_status_in;
   logic       st_refused_ff, st_refused_in;
   logic       st_lvalid_ff, st_lvalid_in;
   logic       st_rdok_ff, st_rdok_in;

   // Output register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff   <= op_type'(req_tuser);
         byte_ff <= req_tdata[7:0];
         fe_ff   <= req_tdata[8];
         ovr_ff  <= req_tdata[9];
      end
   end

   // Wrap pointers at the last entry
   assign rx_nh    = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
   assign rx_nt    = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;
   assign tx_nh    = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
   assign tx_nt    = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign rx_full  = (rx_nh == rx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);
   assign tx_full  = (tx_nh == tx_tail_ff);

   // Execute the held operation
   always_comb begin
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      last_error_in = last_error_ff;
      irq_on_in     = irq_on_ff;
      rx_we         = 1'b0;
      rx_re         = 1'b0;
      tx_we         = 1'b0;
      tx_re         = 1'b0;
      st_status_in  = RS_OK;
      st_refused_in = 1'b0;
      st_lvalid_in  = 1'b0;
      st_rdok_in    = 1'b0;
      if (cmd.exec) begin
         case (op_ff)
            OP_RX_BYTE: begin
               if (rx_full) begin
                  last_error_in = RS_OVERFLOW;
               end else begin
                  rx_head_in    = rx_nh;
                  rx_we         = 1'b1;
                  last_error_in = {1'b0, ovr_ff, fe_ff};
               end
            end
            OP_HOST_READ: begin
               if (rx_empty) begin
                  st_status_in = RS_NO_DATA;
               end else begin
                  rx_tail_in   = rx_nt;
                  rx_re        = 1'b1;
                  st_rdok_in   = 1'b1;
                  st_status_in = last_error_ff;
               end
            end
            OP_HOST_WRITE: begin
               if (tx_full) begin
                  st_refused_in = 1'b1;
               end else begin
                  tx_head_in = tx_nh;
                  tx_we      = 1'b1;
                  irq_on_in  = 1'b1;
               end
            end
            OP_TX_READY: begin
               if (tx_empty) begin
                  irq_on_in = 1'b0;
               end else begin
                  tx_tail_in   = tx_nt;
                  tx_re        = 1'b1;
                  st_lvalid_in = 1'b1;
               end
            end
            default: begin
               irq_on_in = irq_on_ff;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         last_error_ff <= RS_OK;
         irq_on_ff     <= 1'b0;
      end else begin
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         last_error_ff <= last_error_in;
         irq_on_ff     <= irq_on_in;
      end
   end

   // Stage result flags while the memory read completes
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         st_status_ff  <= st_status_in;
         st_refused_ff <= st_refused_in;
         st_lvalid_ff  <= st_lvalid_in;
         st_rdok_ff    <= st_rdok_in;
      end
   end

   // Receive store: push writes at new head, pop reads at new tail
   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_store[rx_nh] <= byte_ff;
      end
      if (rx_re) begin
         rx_rdata_ff <= rx_store[rx_nt];
      end
   end

   // Transmit store
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_store[tx_nh] <= byte_ff;
      end
      if (tx_re) begin
         tx_rdata_ff <= tx_store[tx_nt];
      end
   end

   // Assemble the result word
   assign rsp_data_in = {
      2'b00,
      irq_on_ff,
      (st_lvalid_ff ? tx_rdata_ff : 8'h00),
      st_lvalid_ff,
      st_refused_ff,
      st_status_ff,
      (st_rdok_ff ? rx_rdata_ff : 8'h00)
   };

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   // Output register: hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/uart_rx_tx_ring_buffers.sv -----
// UART receive and transmit ring buffers.
// req channel: one transaction per operation; tuser carries the operation
// (received line byte, host read, host write, transmitter ready) and tdata
// the byte plus the line's frame and overrun flags.
// rsp channel: exactly one transaction per request, carrying the popped
// receive byte and its status, the write-refused flag, the byte handed to
// the transmitter with its valid flag, and the transmitter-ready enable.
// Each buffer holds at most its depth minus one bytes.
// A request passes through execute (with registered store read) and then the
// load of the output register before rsp_tvalid rises; a new request is
// accepted only after the controller has returned to idle, so the block does
// not take a request before it is through with the last one.
// Reset clears all pointers, the recorded error and the ready enable, and
// holds req_tready low; the byte stores are not cleared and are only read
// where written.
// A stalled rsp channel holds the result in the output register; the next
// request is still accepted and executed, then waits until the output
// register frees up.
module uart_rx_tx_ring_buffers #(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] byte_in, [8] frame_error, [9] overrun_error, [15:10] zero
   input  logic [urrb_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [urrb_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [7:0] read_byte, [10:8] read_status, [11] write_refused,
   // [12] line_valid, [20:13] line_byte, [21] ready_enable, [23:22] zero
   output logic [urrb_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import urrb_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   urrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   urrb_datapath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // An accepted transaction executes in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.exec)
      else $error("accepted transaction did not execute");

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

   // No new transaction while one is executing
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !req_tready)
      else $error("request accepted during execute");

endmodule
